[rtl/core/bzp_pkg.sv]
// Shared types and constants of the bilinear zero-pad sampler.
package bzp_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int DIM_W      = 11;
    localparam int PROD_W     = 20;
    localparam int ACC_W      = 34;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_CNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 4'd1;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       inb;
        logic       first;
        logic       last;
        logic       dx;
        logic       dy;
        logic [7:0] fx;
        logic [7:0] fy;
    } bzp_tap_t;

endpackage

[rtl/core/bzp_map_mem.sv]
// Single-port correlation map memory with registered read data.
module bzp_map_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [15:0]       wdata,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/bzp_seq.sv]
// Item holding register and map access sequencer: one write or four neighbour reads.
module bzp_seq #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [11:0]                 s_entry_index,
    input  logic signed [15:0]          s_entry_value,
    input  logic signed [15:0]          s_center_x,
    input  logic signed [15:0]          s_center_y,
    input  logic signed [15:0]          s_offset_x,
    input  logic signed [15:0]          s_offset_y,
    input  logic [bzp_pkg::DIM_W-1:0]   w_eff,
    input  logic [bzp_pkg::DIM_W-1:0]   h_eff,
    input  logic                        credit_ok,
    output logic                        sample_start,
    output logic                        mem_en,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_addr,
    output logic [15:0]                 mem_wdata,
    output bzp_pkg::bzp_tap_t           tap
);

    import bzp_pkg::*;

    logic              busy_reg, busy_next;
    logic              func_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic              wok_reg;
    logic [15:0]       wdata_reg;
    logic [8:0]        ix_reg, iy_reg;
    logic [7:0]        fx_reg, fy_reg;
    logic [1:0]        step_reg, step_next;
    bzp_tap_t          tap_reg, tap_next;

    logic              accept, issue, last;
    logic [16:0]       x_sum, y_sum;
    logic [31:0]       idx_ext;
    logic [9:0]        col, row;
    logic              inb;
    logic [PROD_W-1:0] addr_full;

    assign issue  = busy_reg && (func_reg == FUNC_WRITE || step_reg != 2'd0 || credit_ok);
    assign last   = issue && (func_reg == FUNC_WRITE || step_reg == 2'd3);
    assign s_ready = !busy_reg || last;
    assign accept = s_valid && s_ready;
    assign sample_start = issue && func_reg == FUNC_SAMPLE && step_reg == 2'd0;

    assign x_sum   = {s_center_x[15], s_center_x} + {s_offset_x[15], s_offset_x};
    assign y_sum   = {s_center_y[15], s_center_y} + {s_offset_y[15], s_offset_y};
    assign idx_ext = 32'(s_entry_index);

    always_comb begin
        col = {ix_reg[8], ix_reg} + {9'd0, step_reg[0]};
        row = {iy_reg[8], iy_reg} + {9'd0, step_reg[1]};
        inb = !col[9] && !row[9]
              && ({2'b00, col[8:0]} < w_eff) && ({2'b00, row[8:0]} < h_eff);
        addr_full = PROD_W'(row[8:0]) * PROD_W'(w_eff) + PROD_W'(col[8:0]);
    end

    assign mem_en    = issue && (func_reg == FUNC_SAMPLE || wok_reg);
    assign mem_we    = func_reg == FUNC_WRITE;
    assign mem_addr  = (func_reg == FUNC_WRITE) ? waddr_reg : addr_full[ADDR_W-1:0];
    assign mem_wdata = wdata_reg;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept) begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end else begin
            if (last) begin
                busy_next = 1'b0;
            end
            if (issue && func_reg == FUNC_SAMPLE) begin
                step_next = step_reg + 2'd1;
            end
        end
        tap_next.valid = issue && func_reg == FUNC_SAMPLE;
        tap_next.inb   = inb;
        tap_next.first = step_reg == 2'd0;
        tap_next.last  = step_reg == 2'd3;
        tap_next.dx    = step_reg[0];
        tap_next.dy    = step_reg[1];
        tap_next.fx    = fx_reg;
        tap_next.fy    = fy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= 2'd0;
            tap_reg.valid <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            tap_reg  <= tap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= s_func;
            waddr_reg <= idx_ext[ADDR_W-1:0];
            wok_reg   <= idx_ext < 32'(DEPTH);
            wdata_reg <= s_entry_value;
            ix_reg    <= x_sum[16:8];
            iy_reg    <= y_sum[16:8];
            fx_reg    <= x_sum[7:0];
            fy_reg    <= y_sum[7:0];
        end
    end

    assign tap = tap_reg;

    a_step_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && step_reg != 2'd0 && step_reg != 2'd3)
        |=> (busy_reg && step_reg == $past(step_reg) + 2'd1))
        else $error("sample read sequence stalled or skipped a neighbour");

    a_step_only_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != 2'd0) |-> (busy_reg && func_reg == FUNC_SAMPLE))
        else $error("neighbour step active without a held sample item");

endmodule

[rtl/core/bzp_blend.sv]
// Weight, multiply and accumulate of the four neighbours, plus result queue.
module bzp_blend (
    input  logic               aclk,
    input  logic               aresetn,
    input  bzp_pkg::bzp_tap_t  tap,
    input  logic [15:0]        rdata,
    input  logic               sample_start,
    output logic               credit_ok,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_value
);

    import bzp_pkg::*;

    logic                    a_valid_reg, a_first_reg, a_last_reg;
    logic signed [15:0]      a_data_reg;
    logic [16:0]             a_weight_reg;
    logic                    b_valid_reg, b_first_reg, b_last_reg;
    logic signed [ACC_W-1:0] b_prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [15:0]             fifo_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0]    fifo_cnt_reg, fifo_cnt_next;
    logic [OUT_CNT_W-1:0]    inflight_cnt_reg, inflight_cnt_next;

    logic [8:0]              wx, wy;
    logic [17:0]             wprod;
    logic signed [17:0]      wsig;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] sum;
    logic                    push, pop;

    always_comb begin
        wx    = tap.dx ? {1'b0, tap.fx} : 9'd256 - {1'b0, tap.fx};
        wy    = tap.dy ? {1'b0, tap.fy} : 9'd256 - {1'b0, tap.fy};
        wprod = {9'd0, wx} * {9'd0, wy};
        wsig  = {1'b0, a_weight_reg};
        prod  = a_data_reg * wsig;
        sum   = (b_first_reg ? '0 : acc_reg) + b_prod_reg;
    end

    assign push = b_valid_reg && b_last_reg;
    assign pop  = m_valid && m_ready;

    always_comb begin
        fifo_cnt_next     = fifo_cnt_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
        inflight_cnt_next = inflight_cnt_reg + OUT_CNT_W'(sample_start) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fifo_cnt_reg     <= '0;
            inflight_cnt_reg <= '0;
        end else begin
            a_valid_reg      <= tap.valid;
            b_valid_reg      <= a_valid_reg;
            fifo_cnt_reg     <= fifo_cnt_next;
            inflight_cnt_reg <= inflight_cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_first_reg  <= tap.first;
        a_last_reg   <= tap.last;
        a_data_reg   <= tap.inb ? $signed(rdata) : 16'sd0;
        a_weight_reg <= wprod[16:0];
        b_first_reg  <= a_first_reg;
        b_last_reg   <= a_last_reg;
        b_prod_reg   <= prod;
        if (b_valid_reg) begin
            acc_reg <= sum;
        end
        if (push) begin
            fifo_mem[wr_ptr_reg] <= sum[31:16];
        end
    end

    assign credit_ok      = inflight_cnt_reg < OUT_CNT_W'(OUT_DEPTH);
    assign m_valid        = fifo_cnt_reg != '0;
    assign m_sample_value = fifo_mem[rd_ptr_reg];

    a_queue_in_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= inflight_cnt_reg)
        else $error("result queue holds more items than samples in flight");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> fifo_cnt_reg != OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_cnt_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("samples in flight exceed result queue depth");

    a_first_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_last_reg) |-> $past(b_valid_reg, 3))
        else $error("sample finished without four neighbour taps");

endmodule

[rtl/core/bilinear_zero_pad_sampler.sv]
// Top level of the bilinear zero-pad sampler over one correlation map.
//
//   channel | ports        | handshake       | payload
//   --------+--------------+-----------------+--------------------------------------
//   input   | s_*          | s_valid/s_ready | func, entry_index/value, center, offset
//   result  | m_*          | m_valid/m_ready | sample_value
//   config  | cfg_*        | cfg_we          | cfg_index, cfg_data
//
// A write item uses the single map port once; a sample item makes four reads, one
// per neighbour. Up to 4 samples may be in flight or queued; past that the next
// sample waits in the holding register and s_ready stays low.
// Reset clears control state only; map entries are undefined until written.
module bilinear_zero_pad_sampler #(
    parameter int MAX_WIDTH  = bzp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bzp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bzp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bzp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [11:0]                      s_entry_index,
    input  logic signed [15:0]               s_entry_value,
    input  logic signed [15:0]               s_center_x,
    input  logic signed [15:0]               s_center_y,
    input  logic signed [15:0]               s_offset_x,
    input  logic signed [15:0]               s_offset_y,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [15:0]               m_sample_value
);

    import bzp_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CFG_DATA_W-1:0] map_width_reg, map_height_reg;
    logic [31:0]           w32, h32, w_clamp, h_clamp;
    logic [DIM_W-1:0]      w_eff, h_eff;

    logic                  credit_ok, sample_start;
    logic                  mem_en, mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [15:0]           mem_wdata, mem_rdata;
    bzp_tap_t              tap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= CFG_DATA_W'(64);
            map_height_reg <= CFG_DATA_W'(64);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAP_WIDTH: begin
                    map_width_reg <= cfg_data;
                end
                REG_MAP_HEIGHT: begin
                    map_height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w32 = 32'(map_width_reg);
        h32 = 32'(map_height_reg);
        w_clamp = (w32 == 32'd0) ? 32'd1 : (w32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w32;
        h_clamp = (h32 == 32'd0) ? 32'd1 : (h32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : h32;
        w_eff = w_clamp[DIM_W-1:0];
        h_eff = h_clamp[DIM_W-1:0];
    end

    bzp_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_offset_x    (s_offset_x),
        .s_offset_y    (s_offset_y),
        .w_eff         (w_eff),
        .h_eff         (h_eff),
        .credit_ok     (credit_ok),
        .sample_start  (sample_start),
        .mem_en        (mem_en),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .tap           (tap)
    );

    bzp_map_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_map_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bzp_blend u_blend (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tap            (tap),
        .rdata          (mem_rdata),
        .sample_start   (sample_start),
        .credit_ok      (credit_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value)
    );

endmodule
